### design/mlp_pkg.sv
// Shared types, constants and helper functions for the two-input perceptron core.
`timescale 1ns / 1ps

package mlp_pkg;

  localparam int HIDDEN_DEF    = 4;
  localparam int SIG_DEPTH_DEF = 1024;

  localparam logic [1:0] OP_INFER = 2'd0;
  localparam logic [1:0] OP_TRAIN = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam int        SLOT_W   = 6;
  localparam int        LR_W     = 19;
  localparam logic [LR_W-1:0] LR_RESET = 19'd65536;
  localparam logic [16:0] Q_ONE  = 17'd65536;
  localparam logic [16:0] Q_HALF = 17'd32768;
  localparam int        SPAN     = 524288;

  // State of one hidden unit as it travels around the ring.
  typedef struct packed {
    logic signed [31:0] w0;
    logic signed [31:0] w1;
    logic signed [31:0] b;
    logic signed [31:0] v;
    logic [16:0]        act;
  } unit_t;

  // Parameter write request seen by every cell.
  typedef struct packed {
    logic                en;
    logic [SLOT_W-1:0]   slot;
    logic signed [31:0]  value;
  } wr_t;

  function automatic logic fits32(input logic signed [47:0] v);
    return (v <= 48'sh0000_7FFF_FFFF) && (v >= -48'sh0000_8000_0000);
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -48'sh0000_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Restoring long division, used only while building the table.
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned dv);
    longint unsigned q, r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | ((n >> i) & 64'd1);
      if (r >= dv) begin
        r = r - dv;
        q = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  // Sigmoid table entry, evaluated at elaboration only.
  function automatic logic [16:0] sig_entry(input int idx, input int depth);
    longint unsigned n, q, bitv, u, a, term, e, d, s;
    longint x, sum;
    n = longint'(idx) * 1048576;
    q = 0;
    for (int k = 20; k >= 0; k--) begin
      bitv = 64'd1 << k;
      if ((q | bitv) * longint'(depth) <= n) q = q | bitv;
    end
    x = longint'(q) - SPAN;
    u = (x < 0) ? -x : x;
    a = u << 11;
    term = 64'd1 << 30;
    sum = 64'sd1 << 30;
    for (int k = 1; k <= 16; k++) begin
      term = udiv64((term * a) >> 30, 64'(k));
      if (k[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    e = sum;
    for (int r = 0; r < 3; r++) e = (e * e) >> 30;
    d = (64'd1 << 30) + e;
    if (x >= 0) s = udiv64((64'd1 << 46) + (d >> 1), d);
    else s = udiv64(e * 65536 + (d >> 1), d);
    return s[16:0];
  endfunction

endpackage

### design/mlp_in_if.sv
// Input channel: one operation per transaction.
`timescale 1ns / 1ps

interface mlp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic               bit_a;
  logic               bit_b;
  logic [5:0]         param_index;
  logic signed [31:0] param_value;

  modport source(output valid, operation, bit_a, bit_b, param_index, param_value,
                 input ready);
  modport sink(input valid, operation, bit_a, bit_b, param_index, param_value,
               output ready);
endinterface

### design/mlp_out_if.sv
// Output channel: one result per transaction.
`timescale 1ns / 1ps

interface mlp_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] output_level;
  logic        predicted_bit;
  logic        saturated;

  modport source(output valid, output_level, predicted_bit, saturated, input ready);
  modport sink(input valid, output_level, predicted_bit, saturated, output ready);
endinterface

### design/mlp_cell.sv
// One hidden-unit cell of the rotating parameter ring.
`timescale 1ns / 1ps

module mlp_cell #(
  parameter int HIDDEN = mlp_pkg::HIDDEN_DEF,
  parameter int IDX    = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  mlp_pkg::unit_t nbr,
  input  mlp_pkg::wr_t  wr,
  output mlp_pkg::unit_t q
);

  localparam logic [mlp_pkg::SLOT_W-1:0] SLOT_W0 = mlp_pkg::SLOT_W'(2 * IDX);
  localparam logic [mlp_pkg::SLOT_W-1:0] SLOT_W1 = mlp_pkg::SLOT_W'(2 * IDX + 1);
  localparam logic [mlp_pkg::SLOT_W-1:0] SLOT_B  = mlp_pkg::SLOT_W'(2 * HIDDEN + IDX);
  localparam logic [mlp_pkg::SLOT_W-1:0] SLOT_V  = mlp_pkg::SLOT_W'(3 * HIDDEN + IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= nbr;
    end else if (wr.en) begin
      // Writes only happen while the ring sits at its home position.
      if (wr.slot == SLOT_W0) q.w0 <= wr.value;
      if (wr.slot == SLOT_W1) q.w1 <= wr.value;
      if (wr.slot == SLOT_B)  q.b  <= wr.value;
      if (wr.slot == SLOT_V)  q.v  <= wr.value;
    end
  end

endmodule

### design/mlp_sigmoid.sv
// Sigmoid lookup: registered index computation, then registered table read.
`timescale 1ns / 1ps

module mlp_sigmoid #(
  parameter int DEPTH = mlp_pkg::SIG_DEPTH_DEF
) (
  input  logic               clk,
  input  logic signed [31:0] x,
  output logic [16:0]        y
);

  localparam int IW = $clog2(DEPTH);
  localparam int DW = $clog2(DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_C = DW'(DEPTH);
  localparam logic [IW-1:0] LAST    = IW'(DEPTH - 1);

  logic [16:0]      tab [DEPTH];
  logic [IW-1:0]    idx;
  logic [IW-1:0]    idx_next;
  logic [19:0]      off;
  logic [DW+19:0]   prod;

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_tab
    localparam logic [16:0] ENT = mlp_pkg::sig_entry(gi, DEPTH);
    assign tab[gi] = ENT;
  end

  assign off  = 20'(x + 32'sd524288);
  assign prod = off * DEPTH_C;

  always_comb begin
    if (x < -32'sd524288) idx_next = '0;
    else if (x >= 32'sd524288) idx_next = LAST;
    else idx_next = prod[20 +: IW];
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    y   <= tab[idx];
  end

endmodule

### design/mlp_two_input_train_infer_core.sv
// Top level of the two-input perceptron: sequencer, arithmetic and parameter ring.
//
// Usage: items arrive on in_ch (valid/ready). Operation 0 infers, 1 trains one
// backpropagation step toward XNOR(bit_a, bit_b), 2 writes one parameter slot.
// Every item yields exactly one transaction on out_ch carrying the output
// activation, the decision bit and a saturation flag (all zero for writes).
// The learning rate is set through cfg_write_en/cfg_write_data while idle.
// Hidden units live in a ring of cells that rotates past one shared datapath.
// An inference steps through FSUM, FLK1, FLK2, FACT and FACC for each unit, then
// OSUM, OLK1, OLK2 and OY; training adds BOD1, BOD2, BOB1, BOB2 and then BSA to
// BUPD for each unit; a write goes straight to DONE. One item is in work at a time
// and the next is taken from the cycle after the result is loaded. The per-unit steps
// are set by the sigmoid lookup (two registered stages) and one multiply per step.
// A finished result sits in the output register; the core accepts the next
// item meanwhile and holds its own result until the receiver takes the old one.
// Reset clears all weights, biases and the output valid flag, and sets the
// learning rate to one.
`timescale 1ns / 1ps

module mlp_two_input_train_infer_core #(
  parameter int HIDDEN              = mlp_pkg::HIDDEN_DEF,
  parameter int SIGMOID_TABLE_DEPTH = mlp_pkg::SIG_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  mlp_in_if.sink                    in_ch,
  mlp_out_if.source                 out_ch,
  input  logic                      cfg_write_en,
  input  logic [mlp_pkg::LR_W-1:0]  cfg_write_data
);

  localparam int UW = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
  localparam logic [UW-1:0] LAST_UNIT = UW'(HIDDEN - 1);
  localparam logic [mlp_pkg::SLOT_W-1:0] SLOT_OB = mlp_pkg::SLOT_W'(4 * HIDDEN);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_FSUM = 5'd1;
  localparam logic [4:0] S_FLK1 = 5'd2;
  localparam logic [4:0] S_FLK2 = 5'd3;
  localparam logic [4:0] S_FACT = 5'd4;
  localparam logic [4:0] S_FACC = 5'd5;
  localparam logic [4:0] S_OSUM = 5'd6;
  localparam logic [4:0] S_OLK1 = 5'd7;
  localparam logic [4:0] S_OLK2 = 5'd8;
  localparam logic [4:0] S_OY   = 5'd9;
  localparam logic [4:0] S_BOD1 = 5'd10;
  localparam logic [4:0] S_BOD2 = 5'd11;
  localparam logic [4:0] S_BOB1 = 5'd12;
  localparam logic [4:0] S_BOB2 = 5'd13;
  localparam logic [4:0] S_BSA  = 5'd14;
  localparam logic [4:0] S_BT1  = 5'd15;
  localparam logic [4:0] S_BHD  = 5'd16;
  localparam logic [4:0] S_BHS  = 5'd17;
  localparam logic [4:0] S_BT2  = 5'd18;
  localparam logic [4:0] S_BOS  = 5'd19;
  localparam logic [4:0] S_BUPD = 5'd20;
  localparam logic [4:0] S_DONE = 5'd21;

  logic [4:0]               state;
  logic [UW-1:0]            unit;
  logic [1:0]               op;
  logic                     a_r;
  logic                     b_r;
  logic                     sat;
  logic [mlp_pkg::LR_W-1:0] lr;
  logic signed [31:0]       obias;
  logic signed [31:0]       sx;
  logic [16:0]              sig_y;
  logic [16:0]              y_r;
  logic [16:0]              act_r;
  logic signed [37:0]       acc;
  logic signed [49:0]       p_fw_r;
  logic signed [17:0]       diff_r;
  logic [16:0]              slope_r;
  logic signed [17:0]       od;
  logic signed [21:0]       obstep;
  logic [16:0]              sa;
  logic signed [33:0]       t1;
  logic signed [35:0]       hd;
  logic signed [39:0]       hstep;
  logic signed [19:0]       t2;
  logic signed [23:0]       ostep;
  logic                     out_valid;
  logic [16:0]              o_level;
  logic                     o_pred;
  logic                     o_sat;

  mlp_pkg::unit_t cell_q [HIDDEN];
  mlp_pkg::unit_t head;
  mlp_pkg::unit_t fb;
  mlp_pkg::wr_t   wr;
  logic           rot;
  logic           accept;
  logic           out_free;

  assign head     = cell_q[0];
  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  assign wr.en    = accept && (in_ch.operation == mlp_pkg::OP_WRITE);
  assign wr.slot  = in_ch.param_index;
  assign wr.value = in_ch.param_value;

  for (genvar gi = 0; gi < HIDDEN; gi++) begin : g_cell
    if (gi == HIDDEN - 1) begin : g_tail
      mlp_cell #(.HIDDEN(HIDDEN), .IDX(gi)) u_cell (
        .clk(clk), .rst(rst), .shift(rot), .nbr(fb), .wr(wr), .q(cell_q[gi])
      );
    end else begin : g_mid
      mlp_cell #(.HIDDEN(HIDDEN), .IDX(gi)) u_cell (
        .clk(clk), .rst(rst), .shift(rot), .nbr(cell_q[gi+1]), .wr(wr), .q(cell_q[gi])
      );
    end
  end

  mlp_sigmoid #(.DEPTH(SIGMOID_TABLE_DEPTH)) u_sig (
    .clk(clk), .x(sx), .y(sig_y)
  );

  // Combinational arithmetic, one multiply per step.
  logic signed [33:0] hsum;
  logic signed [47:0] hsum48;
  logic signed [47:0] acc48;
  logic [16:0]        slope_in;
  logic [33:0]        slope_prod;
  logic signed [17:0] diff;
  logic signed [49:0] p_fw;
  logic signed [35:0] p_od;
  logic signed [37:0] p_ob;
  logic signed [49:0] p_t1;
  logic signed [51:0] p_hd;
  logic signed [55:0] p_hs;
  logic signed [35:0] p_t2;
  logic signed [39:0] p_os;
  logic signed [19:0] lr_s;
  logic signed [47:0] ob_sum;
  logic signed [47:0] nb_sum;
  logic signed [47:0] nw0_sum;
  logic signed [47:0] nw1_sum;
  logic signed [47:0] nv_sum;

  assign lr_s = $signed({1'b0, lr});
  assign hsum = 34'(head.b) + (a_r ? 34'(head.w0) : 34'sd0) + (b_r ? 34'(head.w1) : 34'sd0);
  assign hsum48 = 48'(hsum);
  assign acc48  = 48'(acc);
  assign slope_in   = (state == S_BOD1) ? y_r : head.act;
  assign slope_prod = slope_in * (mlp_pkg::Q_ONE - slope_in);
  assign diff = ((a_r == b_r) ? 18'sd65536 : 18'sd0) - $signed({1'b0, y_r});
  assign p_fw = $signed({1'b0, sig_y}) * head.v;
  assign p_od = diff_r * $signed({1'b0, slope_r});
  assign p_ob = od * lr_s;
  assign p_t1 = od * head.v;
  assign p_hd = t1 * $signed({1'b0, sa});
  assign p_hs = hd * lr_s;
  assign p_t2 = $signed({1'b0, head.act}) * od;
  assign p_os = t2 * lr_s;
  assign ob_sum  = 48'(obias) + 48'(obstep);
  assign nb_sum  = 48'(head.b) + 48'(hstep);
  assign nw0_sum = 48'(head.w0) + 48'(hstep);
  assign nw1_sum = 48'(head.w1) + 48'(hstep);
  assign nv_sum  = 48'(head.v) + 48'(ostep);

  always_comb begin
    fb  = head;
    rot = 1'b0;
    case (state)
      S_FACC: begin
        fb.act = act_r;
        rot    = 1'b1;
      end
      S_BUPD: begin
        fb.b = mlp_pkg::clip32(nb_sum);
        fb.v = mlp_pkg::clip32(nv_sum);
        if (a_r) fb.w0 = mlp_pkg::clip32(nw0_sum);
        if (b_r) fb.w1 = mlp_pkg::clip32(nw1_sum);
        rot = 1'b1;
      end
      default: begin
        rot = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      unit      <= '0;
      op        <= mlp_pkg::OP_INFER;
      a_r       <= 1'b0;
      b_r       <= 1'b0;
      sat       <= 1'b0;
      lr        <= mlp_pkg::LR_RESET;
      obias     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_en) lr <= cfg_write_data;
      // A new result loaded in the done state replaces the one taken this cycle.
      if (out_valid && out_ch.ready && (state != S_DONE)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op   <= in_ch.operation;
            a_r  <= in_ch.bit_a;
            b_r  <= in_ch.bit_b;
            sat  <= 1'b0;
            y_r  <= '0;
            unit <= '0;
            acc  <= 38'(obias);
            if (wr.en && (wr.slot == SLOT_OB)) obias <= wr.value;
            if (in_ch.operation == mlp_pkg::OP_INFER ||
                in_ch.operation == mlp_pkg::OP_TRAIN) begin
              state <= S_FSUM;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_FSUM: begin
          sx <= mlp_pkg::clip32(hsum48);
          if (!mlp_pkg::fits32(hsum48)) sat <= 1'b1;
          state <= S_FLK1;
        end
        S_FLK1: state <= S_FLK2;
        S_FLK2: state <= S_FACT;
        S_FACT: begin
          act_r  <= sig_y;
          p_fw_r <= p_fw;
          state  <= S_FACC;
        end
        S_FACC: begin
          acc <= acc + 38'($signed(p_fw_r[49:16]));
          if (unit == LAST_UNIT) begin
            unit  <= '0;
            state <= S_OSUM;
          end else begin
            unit  <= unit + 1'b1;
            state <= S_FSUM;
          end
        end
        S_OSUM: begin
          sx <= mlp_pkg::clip32(acc48);
          if (!mlp_pkg::fits32(acc48)) sat <= 1'b1;
          state <= S_OLK1;
        end
        S_OLK1: state <= S_OLK2;
        S_OLK2: state <= S_OY;
        S_OY: begin
          y_r <= sig_y;
          if (op == mlp_pkg::OP_TRAIN) state <= S_BOD1;
          else state <= S_DONE;
        end
        S_BOD1: begin
          diff_r  <= diff;
          slope_r <= slope_prod[32:16];
          state   <= S_BOD2;
        end
        S_BOD2: begin
          od    <= p_od[33:16];
          state <= S_BOB1;
        end
        S_BOB1: begin
          obstep <= p_ob[37:16];
          state  <= S_BOB2;
        end
        S_BOB2: begin
          obias <= mlp_pkg::clip32(ob_sum);
          if (!mlp_pkg::fits32(ob_sum)) sat <= 1'b1;
          state <= S_BSA;
        end
        S_BSA: begin
          sa    <= slope_prod[32:16];
          state <= S_BT1;
        end
        S_BT1: begin
          t1    <= p_t1[49:16];
          state <= S_BHD;
        end
        S_BHD: begin
          hd    <= p_hd[51:16];
          state <= S_BHS;
        end
        S_BHS: begin
          hstep <= p_hs[55:16];
          state <= S_BT2;
        end
        S_BT2: begin
          t2    <= p_t2[35:16];
          state <= S_BOS;
        end
        S_BOS: begin
          ostep <= p_os[39:16];
          state <= S_BUPD;
        end
        S_BUPD: begin
          if (!mlp_pkg::fits32(nb_sum) || !mlp_pkg::fits32(nv_sum) ||
              (a_r && !mlp_pkg::fits32(nw0_sum)) ||
              (b_r && !mlp_pkg::fits32(nw1_sum))) begin
            sat <= 1'b1;
          end
          if (unit == LAST_UNIT) begin
            unit  <= '0;
            state <= S_DONE;
          end else begin
            unit  <= unit + 1'b1;
            state <= S_BSA;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            o_level   <= y_r;
            o_pred    <= (y_r > mlp_pkg::Q_HALF);
            o_sat     <= sat;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.output_level  = o_level;
  assign out_ch.predicted_bit = o_pred;
  assign out_ch.saturated     = o_sat;

endmodule

### verif/tb_top.sv
// Self-checking testbench for the two-input perceptron core.
`timescale 1ns / 1ps

module tb_top;

  localparam int         NUNITS   = mlp_pkg::HIDDEN_DEF;
  localparam int         DEPTH    = mlp_pkg::SIG_DEPTH_DEF;
  localparam int         SW       = mlp_pkg::SLOT_W;
  localparam int         LRW      = mlp_pkg::LR_W;
  localparam longint     SPAN_Q   = mlp_pkg::SPAN;
  localparam logic [1:0] OP_NOP   = 2'd3;
  localparam int         LAST_SLOT = 4 * NUNITS;
  localparam longint     CYCLE_LIMIT = 2000000;
  localparam logic [LRW-1:0] LR_MAX = '1;

  typedef struct packed {
    logic [16:0] level;
    logic        decision;
    logic        sat;
  } result_t;

  logic                clk;
  logic                rst;
  logic                cfg_write_en;
  logic [LRW-1:0]      cfg_write_data;
  mlp_in_if            in_ch();
  mlp_out_if           out_ch();

  mlp_two_input_train_infer_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  // Model copy of the network and the step size.
  longint  sig_tab[DEPTH];
  int      hw[2*NUNITS];
  int      hb[NUNITS];
  int      ow[NUNITS];
  int      ob;
  longint  step_size;

  result_t pending_results[$];
  bit      failed;
  bit      quiet;
  longint  cycles;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic int gap_draw();
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic void build_sigmoid();
    longint x;
    longint sum;
    longint unsigned u, a, term, e, d, s;
    for (int i = 0; i < DEPTH; i++) begin
      x = -SPAN_Q + (longint'(i) * 1048576) / DEPTH;
      u = (x < 0) ? -x : x;
      a = u << 11;
      term = 64'd1 << 30;
      sum = 64'sd1 << 30;
      for (int k = 1; k <= 16; k++) begin
        term = ((term * a) >> 30) / longint'(k);
        if (k % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      e = sum;
      for (int r = 0; r < 3; r++) e = (e * e) >> 30;
      d = (64'd1 << 30) + e;
      if (x >= 0) s = ((64'd1 << 46) + d / 2) / d;
      else s = (e * 65536 + d / 2) / d;
      sig_tab[i] = longint'(s);
    end
  endfunction

  function automatic longint sigmoid_of(longint x);
    longint idx;
    if (x < -SPAN_Q) idx = 0;
    else idx = ((x + SPAN_Q) * DEPTH) >>> 20;
    if (idx >= DEPTH) idx = DEPTH - 1;
    return sig_tab[idx];
  endfunction

  // Q16.16 product, rounded toward minus infinity.
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint clamp32(longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint slope_of(longint y);
    return (y * (65536 - y)) >>> 16;
  endfunction

  function automatic result_t predict_item(logic [1:0] op, bit a, bit b,
                                           logic [SW-1:0] slot,
                                           logic signed [31:0] pv);
    result_t r;
    bit      sat;
    longint  act[NUNITS];
    longint  hd[NUNITS];
    longint  acc, h, y, od, tgt, stp;
    r = '0;
    sat = 1'b0;
    if (op == mlp_pkg::OP_WRITE) begin
      if (slot < 2*NUNITS) hw[slot] = pv;
      else if (slot < 3*NUNITS) hb[slot - 2*NUNITS] = pv;
      else if (slot < 4*NUNITS) ow[slot - 3*NUNITS] = pv;
      else if (slot == LAST_SLOT) ob = pv;
      return r;
    end
    if (op == OP_NOP) return r;
    acc = ob;
    for (int j = 0; j < NUNITS; j++) begin
      h = hb[j];
      if (a) h += hw[2*j];
      if (b) h += hw[2*j+1];
      act[j] = sigmoid_of(clamp32(h, sat));
      acc += qmul(act[j], ow[j]);
    end
    y = sigmoid_of(clamp32(acc, sat));
    if (op == mlp_pkg::OP_TRAIN) begin
      tgt = (a == b) ? 65536 : 0;
      od = qmul(tgt - y, slope_of(y));
      for (int j = 0; j < NUNITS; j++) hd[j] = qmul(qmul(od, ow[j]), slope_of(act[j]));
      ob = int'(clamp32(longint'(ob) + qmul(od, step_size), sat));
      for (int j = 0; j < NUNITS; j++) begin
        stp = qmul(qmul(act[j], od), step_size);
        ow[j] = int'(clamp32(longint'(ow[j]) + stp, sat));
      end
      for (int j = 0; j < NUNITS; j++) begin
        stp = qmul(hd[j], step_size);
        hb[j] = int'(clamp32(longint'(hb[j]) + stp, sat));
        if (a) hw[2*j] = int'(clamp32(longint'(hw[2*j]) + stp, sat));
        if (b) hw[2*j+1] = int'(clamp32(longint'(hw[2*j+1]) + stp, sat));
      end
    end
    r.level = y[16:0];
    r.decision = (y > 32768);
    r.sat = sat;
    return r;
  endfunction

  // Drives one item and records its expected result once the transaction completes.
  task automatic send_item(logic [1:0] op, bit a, bit b, logic [SW-1:0] slot,
                           logic signed [31:0] pv);
    int gap;
    gap = gap_draw();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.bit_a       <= a;
    in_ch.bit_b       <= b;
    in_ch.param_index <= slot;
    in_ch.param_value <= pv;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_item(op, a, b, slot, pv));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_step_size(logic [LRW-1:0] v);
    drain_results();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    step_size = v;
  endtask

  // Result side: random back-pressure and the field-by-field check.
  initial begin
    result_t exp_r;
    int      stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = gap_draw();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing outstanding");
        failed = 1'b1;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.output_level !== exp_r.level) begin
          $error("output_level expected %0d actual %0d", exp_r.level, out_ch.output_level);
          failed = 1'b1;
        end
        if (out_ch.predicted_bit !== exp_r.decision) begin
          $error("predicted_bit expected %0d actual %0d", exp_r.decision,
                 out_ch.predicted_bit);
          failed = 1'b1;
        end
        if (out_ch.saturated !== exp_r.sat) begin
          $error("saturated expected %0d actual %0d", exp_r.sat, out_ch.saturated);
          failed = 1'b1;
        end
      end
      @(negedge clk);
    end
  end

  task automatic load_network(int span);
    for (int s = 0; s <= LAST_SLOT; s++)
      send_item(mlp_pkg::OP_WRITE, 0, 0, SW'(s), $signed($urandom_range(0, 2*span)) - span);
  endtask

  task automatic test_writes_and_ignored_items();
    for (int s = 0; s <= LAST_SLOT; s++)
      send_item(mlp_pkg::OP_WRITE, 0, 0, SW'(s), 32'sh0001_0000 * s);
    send_item(mlp_pkg::OP_WRITE, 1, 1, 6'd63, 32'sh7FFF_FFFF);
    send_item(mlp_pkg::OP_WRITE, 0, 1, SW'(LAST_SLOT + 1), 32'sh8000_0000);
    send_item(OP_NOP, 1, 0, 6'd0, 32'sh1234_5678);
    for (int k = 0; k < 4; k++) send_item(mlp_pkg::OP_INFER, k[0], k[1], 0, 0);
  endtask

  task automatic test_saturation_and_clamps();
    send_item(mlp_pkg::OP_WRITE, 0, 0, 0, 32'sh7FFF_FFFF);
    send_item(mlp_pkg::OP_WRITE, 0, 0, 1, 32'sh7FFF_FFFF);
    send_item(mlp_pkg::OP_WRITE, 0, 0, 2, 32'sh8000_0000);
    send_item(mlp_pkg::OP_WRITE, 0, 0, 3, 32'sh8000_0000);
    send_item(mlp_pkg::OP_WRITE, 0, 0, SW'(LAST_SLOT), 32'sh7FFF_FFFF);
    send_item(mlp_pkg::OP_WRITE, 0, 0, SW'(3*NUNITS), 32'sh7FFF_FFFF);
    send_item(mlp_pkg::OP_INFER, 1, 1, 0, 0);
    send_item(mlp_pkg::OP_TRAIN, 1, 1, 0, 0);
    send_item(mlp_pkg::OP_TRAIN, 1, 0, 0, 0);
    send_item(mlp_pkg::OP_WRITE, 0, 0, SW'(LAST_SLOT), 32'sh8000_0000);
    send_item(mlp_pkg::OP_TRAIN, 0, 1, 0, 0);
    send_item(mlp_pkg::OP_TRAIN, 0, 0, 0, 0);
  endtask

  // Mostly coherent learning sequences, with a share of arbitrary noise.
  task automatic test_random_training(int count, int span);
    int pick;
    load_network(span);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        send_item(mlp_pkg::OP_TRAIN, 1'($urandom), 1'($urandom), SW'($urandom), $urandom);
      else if (pick < 75)
        send_item(mlp_pkg::OP_INFER, 1'($urandom), 1'($urandom), SW'($urandom), $urandom);
      else if (pick < 93)
        send_item(mlp_pkg::OP_WRITE, 1'($urandom), 1'($urandom),
                  SW'($urandom_range(0, LAST_SLOT)),
                  $signed($urandom_range(0, 2*span)) - span);
      else send_item(2'($urandom), 1'($urandom), 1'($urandom), SW'($urandom_range(0, 63)),
                     $urandom);
    end
  endtask

  initial begin
    failed = 1'b0;
    quiet = 1'b0;
    cycles = 0;
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = mlp_pkg::OP_INFER;
    in_ch.bit_a = 1'b0;
    in_ch.bit_b = 1'b0;
    in_ch.param_index = '0;
    in_ch.param_value = '0;
    build_sigmoid();
    foreach (hw[i]) hw[i] = 0;
    foreach (hb[i]) begin
      hb[i] = 0;
      ow[i] = 0;
    end
    ob = 0;
    step_size = mlp_pkg::LR_RESET;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_writes_and_ignored_items();
    set_step_size(LR_MAX);
    test_saturation_and_clamps();

    set_step_size(19'd262144);
    test_random_training(400, 262144);
    set_step_size(19'd0);
    quiet = 1'b1;
    test_random_training(200, 524288);
    quiet = 1'b0;
    set_step_size(mlp_pkg::LR_RESET);
    test_random_training(400, 196608);
    set_step_size(LRW'($urandom));
    test_random_training(300, 1048576);
    set_step_size(LR_MAX);
    test_random_training(300, 131072);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (!failed) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule
